### sv/nsfv_pkg.sv
// Shared types and constants for the NMEA sentence framer and validator.
package nsfv_pkg;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_LOW     = 8'h20;
    localparam logic [7:0] CH_HIGH    = 8'h7E;

    localparam int LEN_W  = 11;
    localparam int TIME_W = 63;
    localparam int FC_W   = 6;

    typedef enum logic [1:0] {
        REG_MAX_LINE     = 2'd0,
        REG_MAX_SENTENCE = 2'd1,
        REG_ALLOW_NO_CS  = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_LONG     = 3'd1,
        ST_TOO_SHORT    = 3'd2,
        ST_BAD_CHAR     = 3'd3,
        ST_BAD_HEX      = 3'd4,
        ST_NO_CHECKSUM  = 3'd5,
        ST_TOO_MANY     = 3'd6,
        ST_BAD_CHECKSUM = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        TY_UNKNOWN = 3'd0,
        TY_GGA     = 3'd1,
        TY_RMC     = 3'd2,
        TY_GST     = 3'd3,
        TY_GSA     = 3'd4,
        TY_VTG     = 3'd5
    } sentence_type_t;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic [TIME_W-1:0] arrival_time;
    } in_item_t;

    typedef struct packed {
        logic [LEN_W-1:0] line_cap_bytes;
        logic [LEN_W-1:0] max_sentence_bytes;
        logic             accept_bare;
    } cfg_t;

    typedef struct packed {
        status_t           status;
        sentence_type_t    sentence_type;
        logic              is_proprietary;
        logic [7:0]        talker_first;
        logic [7:0]        talker_second;
        logic [FC_W-1:0]   num_fields;
        logic              star_found;
        logic [7:0]        received_checksum;
        logic [7:0]        computed_checksum;
        logic [LEN_W-1:0]  line_length;
        logic [TIME_W-1:0] line_time;
    } descriptor_t;

endpackage

### sv/nsfv_in_reg.sv
// Input register stage: holds one accepted byte until the parser takes it.
module nsfv_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  nsfv_pkg::in_item_t in_item,
    output logic              item_valid,
    output nsfv_pkg::in_item_t item,
    input  logic              advance
);
    import nsfv_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

### sv/nsfv_line_parser.sv
// Per-byte line state tracking and descriptor building on line close.
module nsfv_line_parser #(
    parameter int MAX_FIELDS = 32,
    parameter int LINE_LIMIT = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  nsfv_pkg::cfg_t         cfg,
    input  logic                   item_valid,
    input  nsfv_pkg::in_item_t     item,
    input  logic                   fire,
    output logic                   emit_req,
    output nsfv_pkg::descriptor_t  desc
);
    import nsfv_pkg::*;

    localparam int CW      = $clog2(MAX_FIELDS + 2);
    localparam int CAP     = (LINE_LIMIT > 2047) ? 2047 : LINE_LIMIT;
    localparam logic [LEN_W-1:0] LIMIT_CAP  = LEN_W'(CAP);
    localparam logic [CW-1:0]    FIELDS_MAX = CW'(MAX_FIELDS);
    localparam logic [CW-1:0]    COMMA_SAT  = CW'(MAX_FIELDS + 1);

    logic             overflow_reg,     overflow_next;
    logic [LEN_W-1:0] stored_len_reg,   stored_len_next;
    logic             star_seen_reg,    star_seen_next;
    logic [1:0]       hex_count_reg,    hex_count_next;
    logic             hex_valid_reg,    hex_valid_next;
    logic [7:0]       hex_value_reg,    hex_value_next;
    logic [2:0]       body_count_reg,   body_count_next;
    logic [7:0]       body_xor_reg,     body_xor_next;
    logic             bad_char_reg,     bad_char_next;
    logic [2:0]       addr_len_reg,     addr_len_next;
    logic             addr_done_reg,    addr_done_next;
    logic [7:0]       head_reg [5];
    logic [7:0]       head_next [5];
    logic [CW-1:0]    comma_reg,        comma_next;

    logic [7:0]       c;
    logic             is_term;
    logic             is_start;
    logic [LEN_W-1:0] limit;
    logic [4:0]       hex_digit;
    logic             filled;
    status_t          status;

    function automatic logic [4:0] hex_of(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'b0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            r = {1'b1, 4'(ch - 8'h30)};
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            r = {1'b1, 4'(ch - 8'h37)};
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            r = {1'b1, 4'(ch - 8'h57)};
        end
        return r;
    endfunction

    function automatic sentence_type_t type_of(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] d);
        sentence_type_t t;
        t = TY_UNKNOWN;
        if (a == 8'h47 && b == 8'h47 && d == 8'h41) begin
            t = TY_GGA;
        end else if (a == 8'h52 && b == 8'h4D && d == 8'h43) begin
            t = TY_RMC;
        end else if (a == 8'h47 && b == 8'h53 && d == 8'h54) begin
            t = TY_GST;
        end else if (a == 8'h47 && b == 8'h53 && d == 8'h41) begin
            t = TY_GSA;
        end else if (a == 8'h56 && b == 8'h54 && d == 8'h47) begin
            t = TY_VTG;
        end
        return t;
    endfunction

    assign c         = item.data_byte;
    assign is_term   = (c == CH_CR) || (c == CH_LF);
    assign is_start  = (c == CH_DOLLAR) || (c == CH_BANG);
    assign limit     = (cfg.line_cap_bytes < LIMIT_CAP) ? cfg.line_cap_bytes : LIMIT_CAP;
    assign hex_digit = hex_of(c);
    assign emit_req  = item_valid && is_term && (stored_len_reg != '0);

    // Status in fixed precedence, from the state before this byte.
    always_comb begin
        filled = 1'b0;
        if (overflow_reg || stored_len_reg > cfg.max_sentence_bytes) begin
            status = ST_TOO_LONG;
        end else if (body_count_reg < 3'd5) begin
            status = ST_TOO_SHORT;
        end else if (bad_char_reg) begin
            status = ST_BAD_CHAR;
        end else if (star_seen_reg && (hex_count_reg < 2'd2 || !hex_valid_reg)) begin
            status = ST_BAD_HEX;
        end else if (!star_seen_reg && !cfg.accept_bare) begin
            status = ST_NO_CHECKSUM;
        end else if (addr_len_reg < 3'd5) begin
            status = ST_TOO_SHORT;
        end else begin
            filled = 1'b1;
            if (comma_reg > FIELDS_MAX) begin
                status = ST_TOO_MANY;
            end else if (star_seen_reg && body_xor_reg != hex_value_reg) begin
                status = ST_BAD_CHECKSUM;
            end else begin
                status = ST_OK;
            end
        end
    end

    always_comb begin
        desc = '0;
        desc.status            = status;
        desc.computed_checksum = body_xor_reg;
        desc.line_length       = stored_len_reg;
        desc.line_time         = item.arrival_time;
        if (filled) begin
            desc.star_found        = star_seen_reg;
            desc.received_checksum = star_seen_reg ? hex_value_reg : 8'h00;
            desc.num_fields        = (comma_reg > FIELDS_MAX) ? FC_W'(FIELDS_MAX)
                                                              : FC_W'(comma_reg);
            desc.talker_first      = head_reg[0];
            if (head_reg[0] == CH_P) begin
                desc.is_proprietary = 1'b1;
            end else begin
                desc.talker_second = head_reg[1];
                if (addr_len_reg == 3'd5) begin
                    desc.sentence_type = type_of(head_reg[2], head_reg[3], head_reg[4]);
                end
            end
        end
    end

    always_comb begin
        overflow_next   = overflow_reg;
        stored_len_next = stored_len_reg;
        star_seen_next  = star_seen_reg;
        hex_count_next  = hex_count_reg;
        hex_valid_next  = hex_valid_reg;
        hex_value_next  = hex_value_reg;
        body_count_next = body_count_reg;
        body_xor_next   = body_xor_reg;
        bad_char_next   = bad_char_reg;
        addr_len_next   = addr_len_reg;
        addr_done_next  = addr_done_reg;
        head_next       = head_reg;
        comma_next      = comma_reg;
        if (is_term) begin
            // Close the line, or just drop the oversize mark on an empty one.
            overflow_next = 1'b0;
            if (stored_len_reg != '0) begin
                stored_len_next = '0;
                star_seen_next  = 1'b0;
                hex_count_next  = 2'd0;
                hex_valid_next  = 1'b1;
                hex_value_next  = 8'h00;
                body_count_next = 3'd0;
                body_xor_next   = 8'h00;
                bad_char_next   = 1'b0;
                addr_len_next   = 3'd0;
                addr_done_next  = 1'b0;
                for (int i = 0; i < 5; i++) begin
                    head_next[i] = 8'h00;
                end
                comma_next = '0;
            end
        end else if (stored_len_reg == '0 && !is_start) begin
            // Drop bytes outside a line.
        end else if (stored_len_reg >= limit) begin
            overflow_next = 1'b1;
        end else if (stored_len_reg == '0) begin
            stored_len_next = LEN_W'(1);
        end else begin
            stored_len_next = stored_len_reg + LEN_W'(1);
            if (star_seen_reg) begin
                if (hex_count_reg < 2'd2) begin
                    if (!hex_digit[4]) begin
                        hex_valid_next = 1'b0;
                    end else begin
                        hex_value_next = {hex_value_reg[3:0], hex_digit[3:0]};
                    end
                    hex_count_next = hex_count_reg + 2'd1;
                end
            end else if (c == CH_STAR) begin
                star_seen_next = 1'b1;
            end else begin
                body_xor_next = body_xor_reg ^ c;
                if (c < CH_LOW || c > CH_HIGH) begin
                    bad_char_next = 1'b1;
                end
                if (body_count_reg < 3'd5) begin
                    head_next[body_count_reg] = c;
                    body_count_next = body_count_reg + 3'd1;
                end
                if (c == CH_COMMA) begin
                    addr_done_next = 1'b1;
                    if (comma_reg < COMMA_SAT) begin
                        comma_next = comma_reg + CW'(1);
                    end
                end else if (!addr_done_reg && addr_len_reg < 3'd6) begin
                    addr_len_next = addr_len_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            overflow_reg   <= 1'b0;
            stored_len_reg <= '0;
            star_seen_reg  <= 1'b0;
            hex_count_reg  <= 2'd0;
            hex_valid_reg  <= 1'b1;
            hex_value_reg  <= 8'h00;
            body_count_reg <= 3'd0;
            body_xor_reg   <= 8'h00;
            bad_char_reg   <= 1'b0;
            addr_len_reg   <= 3'd0;
            addr_done_reg  <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                head_reg[i] <= 8'h00;
            end
            comma_reg <= '0;
        end else if (fire) begin
            overflow_reg   <= overflow_next;
            stored_len_reg <= stored_len_next;
            star_seen_reg  <= star_seen_next;
            hex_count_reg  <= hex_count_next;
            hex_valid_reg  <= hex_valid_next;
            hex_value_reg  <= hex_value_next;
            body_count_reg <= body_count_next;
            body_xor_reg   <= body_xor_next;
            bad_char_reg   <= bad_char_next;
            addr_len_reg   <= addr_len_next;
            addr_done_reg  <= addr_done_next;
            head_reg       <= head_next;
            comma_reg      <= comma_next;
        end
    end

endmodule

### sv/nmea_sentence_framer_validator.sv
// Top level of the NMEA sentence framer and validator.
// One received byte is taken per cycle on the s_ stream, back to back, unless a closing
// byte is held as told below; each byte passes an input register and updates the line
// state through flag and XOR logic, and a CR or LF that closes a non-empty line loads one
// descriptor via the input register into the m_ output register behind m_tvalid. A byte
// that closes a line waits in the input register only while a previous descriptor is
// still held by m_tready low; all other bytes pass at one per cycle regardless of the
// output side. There is no clearing pass after reset. Configuration writes on cfg_we are
// taken at any edge and must be made while the block is idle.
module nmea_sentence_framer_validator #(
    parameter int MAX_FIELDS = 32,
    parameter int LINE_LIMIT = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [10:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // data_byte[7:0], arrival_time[70:8], zero[71]
    input  logic [71:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], talker_first[10:3], talker_second[18:11], num_fields[24:19],
    // star_found[25], received_checksum[33:26], computed_checksum[41:34],
    // line_length[52:42], line_time[115:53], zero[119:116]
    output logic [119:0] m_tdata,
    // sentence_type[2:0], is_proprietary[3]
    output logic [3:0]   m_tuser
);
    import nsfv_pkg::*;

    cfg_t        cfg_reg;
    in_item_t    s_item;
    in_item_t    item;
    logic        item_valid;
    logic        emit_req;
    logic        fire;
    descriptor_t desc;
    descriptor_t out_reg;
    logic        out_valid_reg;

    assign s_item.data_byte    = s_tdata[7:0];
    assign s_item.arrival_time = s_tdata[70:8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_cap_bytes     <= 11'd128;
            cfg_reg.max_sentence_bytes <= 11'd128;
            cfg_reg.accept_bare        <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MAX_LINE:     cfg_reg.line_cap_bytes     <= cfg_wdata;
                REG_MAX_SENTENCE: cfg_reg.max_sentence_bytes <= cfg_wdata;
                REG_ALLOW_NO_CS:  cfg_reg.accept_bare        <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Hold a closing byte only while the output register is occupied and stalled.
    assign fire = item_valid && (!emit_req || !out_valid_reg || m_tready);

    nsfv_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (s_item),
        .item_valid (item_valid),
        .item       (item),
        .advance    (fire)
    );

    nsfv_line_parser #(
        .MAX_FIELDS (MAX_FIELDS),
        .LINE_LIMIT (LINE_LIMIT)
    ) u_line_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .fire       (fire),
        .emit_req   (emit_req),
        .desc       (desc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && emit_req) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit_req) begin
            out_reg <= desc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_reg.is_proprietary, out_reg.sentence_type};
    assign m_tdata  = {4'b0,
                       out_reg.line_time,
                       out_reg.line_length,
                       out_reg.computed_checksum,
                       out_reg.received_checksum,
                       out_reg.star_found,
                       out_reg.num_fields,
                       out_reg.talker_second,
                       out_reg.talker_first,
                       out_reg.status};

    // A descriptor always covers at least the start character.
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_reg.line_length != '0)
        else $error("descriptor with zero line length");

    a_ok_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.status == ST_OK && out_reg.star_found
        |-> out_reg.received_checksum == out_reg.computed_checksum)
        else $error("ok status with checksum mismatch");

    a_early_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_reg.status == ST_TOO_LONG || out_reg.status == ST_TOO_SHORT
                          || out_reg.status == ST_BAD_CHAR || out_reg.status == ST_BAD_HEX
                          || out_reg.status == ST_NO_CHECKSUM)
        |-> out_reg.num_fields == '0 && m_tuser == '0 && !out_reg.star_found)
        else $error("early failure status carries parsed fields");

    a_type_not_prop: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.sentence_type != TY_UNKNOWN |-> !out_reg.is_proprietary)
        else $error("known type on proprietary sentence");

endmodule
